FILE: rtl/mbrx_pkg.sv
// shared types, constants and functions of the modbus read-response receiver
package mbrx_pkg;

    localparam logic [7:0]  DEV_ADDR    = 8'h0A;
    localparam logic [7:0]  FUNC_READ   = 8'h03;
    localparam logic [7:0]  COUNT_SHORT = 8'd8;
    localparam logic [7:0]  COUNT_LONG  = 8'd16;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RST = 16'd5;

    localparam int CHANNELS   = 4;
    localparam int CH_W       = 2;
    localparam int DATA_BYTES = 16;
    localparam int DATA_W     = 4;
    localparam int IDX_W      = 5;
    localparam int TOTAL_W    = 5;
    localparam int HDR_BYTES  = 3;

    localparam logic [TOTAL_W-1:0] TOTAL_EXTRA = 5'd5;
    localparam logic [TOTAL_W-1:0] TOTAL_LONG  = 5'd21;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT   = 3'd0,
        CFG_LEFT_CH   = 3'd1,
        CFG_RIGHT_CH  = 3'd2,
        CFG_LEFT_INV  = 3'd3,
        CFG_RIGHT_INV = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic accepted;
        logic crc_error;
        logic format_error;
        logic long_frame;
    } t_parse_evt;

    typedef logic [DATA_BYTES-1:0][7:0] t_data_bytes;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] invert16(input logic [15:0] v, input logic inv);
        logic [15:0] r;
        if (!inv) begin
            r = v;
        end else if (v == 16'h8000) begin
            r = 16'h7FFF;
        end else begin
            r = 16'h0000 - v;
        end
        return r;
    endfunction

endpackage

FILE: rtl/mbrx_parser.sv
// frame parser: timeout, header checks, crc accumulation and data byte capture
module mbrx_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [7:0]           i_rx_byte,
    input  logic [31:0]          i_arrival_ms,
    input  logic [15:0]          i_timeout,
    output mbrx_pkg::t_parse_evt o_evt,
    output mbrx_pkg::t_data_bytes o_data
);

    logic [mbrx_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [mbrx_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [15:0]                  r_crc, n_crc;
    logic [31:0]                  r_last;
    logic [7:0]                   r_prev, n_prev;
    mbrx_pkg::t_data_bytes        r_data, n_data;
    mbrx_pkg::t_parse_evt         evt;
    logic [31:0]                  gap;
    logic [mbrx_pkg::IDX_W-1:0]   off;
    logic                         st;
    logic                         done;

    assign gap = i_arrival_ms - r_last;

    always_comb begin
        n_idx   = r_idx;
        n_total = r_total;
        n_crc   = r_crc;
        n_prev  = r_prev;
        n_data  = r_data;
        evt     = '0;
        off     = '0;
        st      = 1'b0;
        done    = 1'b0;

        // stale partial frame
        if (r_idx != '0 && gap > {16'd0, i_timeout}) begin
            evt.format_error = 1'b1;
            n_idx   = '0;
            n_total = '0;
            n_crc   = mbrx_pkg::CRC_INIT;
        end

        if (n_idx == mbrx_pkg::IDX_W'(0)) begin
            st   = (i_rx_byte == mbrx_pkg::DEV_ADDR);
            done = 1'b1;
        end else if (n_idx == mbrx_pkg::IDX_W'(1)) begin
            if (i_rx_byte != mbrx_pkg::FUNC_READ) begin
                evt.format_error = 1'b1;
                n_idx   = '0;
                n_total = '0;
                n_crc   = mbrx_pkg::CRC_INIT;
                st      = (i_rx_byte == mbrx_pkg::DEV_ADDR);
            end else begin
                st = 1'b1;
            end
            done = 1'b1;
        end else if (n_idx == mbrx_pkg::IDX_W'(2)) begin
            if (i_rx_byte != mbrx_pkg::COUNT_SHORT && i_rx_byte != mbrx_pkg::COUNT_LONG) begin
                evt.format_error = 1'b1;
                n_idx   = '0;
                n_total = '0;
                n_crc   = mbrx_pkg::CRC_INIT;
                done    = 1'b1;
            end else begin
                n_total = i_rx_byte[mbrx_pkg::TOTAL_W-1:0] + mbrx_pkg::TOTAL_EXTRA;
            end
        end

        if (!done) begin
            st = 1'b1;
        end

        if (st) begin
            if (n_total == '0 || ({1'b0, n_idx} + 6'd2) < {1'b0, n_total}) begin
                n_crc = mbrx_pkg::crc16_update(n_crc, i_rx_byte);
            end
            off = n_idx - mbrx_pkg::IDX_W'(mbrx_pkg::HDR_BYTES);
            if (n_idx >= mbrx_pkg::IDX_W'(mbrx_pkg::HDR_BYTES)
                && off < mbrx_pkg::IDX_W'(mbrx_pkg::DATA_BYTES)) begin
                n_data[off[mbrx_pkg::DATA_W-1:0]] = i_rx_byte;
            end
            n_prev = i_rx_byte;
            if (n_total != '0 && (n_idx + mbrx_pkg::IDX_W'(1)) == n_total) begin
                // crc arrives low byte first
                if ({i_rx_byte, r_prev} == n_crc) begin
                    evt.accepted   = 1'b1;
                    evt.long_frame = (n_total == mbrx_pkg::TOTAL_LONG);
                end else begin
                    evt.crc_error = 1'b1;
                end
                n_idx   = '0;
                n_total = '0;
                n_crc   = mbrx_pkg::CRC_INIT;
            end else begin
                n_idx = n_idx + mbrx_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_total <= '0;
            r_crc   <= mbrx_pkg::CRC_INIT;
            r_last  <= '0;
        end else if (i_load) begin
            r_idx   <= n_idx;
            r_total <= n_total;
            r_crc   <= n_crc;
            r_last  <= i_arrival_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prev <= n_prev;
            r_data <= n_data;
        end
    end

    assign o_evt  = evt;
    assign o_data = r_data;

endmodule

FILE: rtl/modbus_encoder_frame_receiver.sv
// Modbus RTU read-response receiver: takes one serial byte per item with its
// millisecond arrival time and returns one result per item. A byte enters an
// input register, is parsed and checked against the frame state and the running
// crc, and its result lands in an output register, so an item is accepted every
// cycle while o_in_stall is low. The byte-wide crc update and the 32-bit gap
// compare set the cycle. A stall on the result side reaches the input stall in
// the same cycle. Configuration is written through a plain write port; the user
// must write it only while the block is idle, which the block does not enforce.
module modbus_encoder_frame_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [mbrx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mbrx_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_rx_byte,
    input  logic [31:0]                     i_arrival_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_frame_accepted,
    output logic                            o_crc_error,
    output logic                            o_format_error,
    output logic                            o_counts_valid,
    output logic                            o_speeds_valid,
    output logic signed [15:0]              o_left_ticks,
    output logic signed [15:0]              o_right_ticks,
    output logic signed [15:0]              o_left_speed,
    output logic signed [15:0]              o_right_speed,
    output logic [31:0]                     o_sample_time_ms
);

    logic [15:0]                 r_timeout;
    logic [mbrx_pkg::CH_W-1:0]   r_left_ch;
    logic [mbrx_pkg::CH_W-1:0]   r_right_ch;
    logic                        r_left_inv;
    logic                        r_right_inv;

    logic                        r_in_valid;
    logic [7:0]                  r_in_byte;
    logic [31:0]                 r_in_ms;

    logic [mbrx_pkg::CHANNELS-1:0][15:0] r_counts, n_counts;
    logic [mbrx_pkg::CHANNELS-1:0][15:0] r_speeds, n_speeds;
    logic [31:0]                 r_sample, n_sample;
    logic                        r_cseen, n_cseen;
    logic                        r_sseen, n_sseen;

    logic                        r_out_valid;
    logic                        r_out_acc;
    logic                        r_out_crc;
    logic                        r_out_fmt;
    logic                        r_out_cseen;
    logic                        r_out_sseen;
    logic [15:0]                 r_out_lc;
    logic [15:0]                 r_out_rc;
    logic [15:0]                 r_out_ls;
    logic [15:0]                 r_out_rs;
    logic [31:0]                 r_out_time;

    logic                        out_free;
    logic                        proc;
    logic                        in_accept;
    mbrx_pkg::t_parse_evt        evt;
    mbrx_pkg::t_data_bytes       data;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= mbrx_pkg::TIMEOUT_RST;
            r_left_ch   <= mbrx_pkg::CH_W'(0);
            r_right_ch  <= mbrx_pkg::CH_W'(1);
            r_left_inv  <= 1'b0;
            r_right_inv <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mbrx_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_wdata;
                mbrx_pkg::CFG_LEFT_CH:   r_left_ch   <= i_cfg_wdata[mbrx_pkg::CH_W-1:0];
                mbrx_pkg::CFG_RIGHT_CH:  r_right_ch  <= i_cfg_wdata[mbrx_pkg::CH_W-1:0];
                mbrx_pkg::CFG_LEFT_INV:  r_left_inv  <= i_cfg_wdata[0];
                mbrx_pkg::CFG_RIGHT_INV: r_right_inv <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
            r_in_ms   <= i_arrival_ms;
        end
    end

    mbrx_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (proc),
        .i_rx_byte    (r_in_byte),
        .i_arrival_ms (r_in_ms),
        .i_timeout    (r_timeout),
        .o_evt        (evt),
        .o_data       (data)
    );

    always_comb begin
        n_counts = r_counts;
        n_speeds = r_speeds;
        n_sample = r_sample;
        n_cseen  = r_cseen;
        n_sseen  = r_sseen;
        if (evt.accepted) begin
            for (int c = 0; c < mbrx_pkg::CHANNELS; c++) begin
                n_counts[c] = {data[2*c], data[2*c+1]};
            end
            if (evt.long_frame) begin
                for (int c = 0; c < mbrx_pkg::CHANNELS; c++) begin
                    n_speeds[c] = {data[2*mbrx_pkg::CHANNELS+2*c],
                                   data[2*mbrx_pkg::CHANNELS+2*c+1]};
                end
                n_sseen = 1'b1;
            end
            n_sample = r_in_ms;
            n_cseen  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts <= '0;
            r_speeds <= '0;
            r_sample <= '0;
            r_cseen  <= 1'b0;
            r_sseen  <= 1'b0;
        end else if (proc) begin
            r_counts <= n_counts;
            r_speeds <= n_speeds;
            r_sample <= n_sample;
            r_cseen  <= n_cseen;
            r_sseen  <= n_sseen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_acc   <= evt.accepted;
            r_out_crc   <= evt.crc_error;
            r_out_fmt   <= evt.format_error;
            r_out_cseen <= n_cseen;
            r_out_sseen <= n_sseen;
            r_out_lc    <= mbrx_pkg::invert16(n_counts[r_left_ch], r_left_inv);
            r_out_rc    <= mbrx_pkg::invert16(n_counts[r_right_ch], r_right_inv);
            r_out_ls    <= mbrx_pkg::invert16(n_speeds[r_left_ch], r_left_inv);
            r_out_rs    <= mbrx_pkg::invert16(n_speeds[r_right_ch], r_right_inv);
            r_out_time  <= n_sample;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_accepted = r_out_acc;
    assign o_crc_error      = r_out_crc;
    assign o_format_error   = r_out_fmt;
    assign o_counts_valid   = r_out_cseen;
    assign o_speeds_valid   = r_out_sseen;
    assign o_left_ticks     = r_out_lc;
    assign o_right_ticks    = r_out_rc;
    assign o_left_speed     = r_out_ls;
    assign o_right_speed    = r_out_rs;
    assign o_sample_time_ms = r_out_time;

`ifndef SYNTHESIS
    a_acc_sets_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_accepted |-> o_counts_valid)
        else $error("accepted frame without counts_valid");

    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cseen |=> r_cseen)
        else $error("counts_seen cleared after being set");

    a_speeds_need_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sseen |-> r_cseen)
        else $error("speeds seen without counts");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result without a pending item");
`endif

endmodule

FILE: sim/tb_top.sv
// self-checking testbench of the modbus read-response receiver: frames, errors, config, stalls
`timescale 1ns / 100ps

module tb_top;

    localparam int          BUF_BYTES   = 32;
    localparam int unsigned QUIET_LIMIT = 1000;

    typedef struct {
        logic        accepted;
        logic        crc_err;
        logic        fmt_err;
        logic        counts_ok;
        logic        speeds_ok;
        logic [15:0] left_cnt;
        logic [15:0] right_cnt;
        logic [15:0] left_spd;
        logic [15:0] right_spd;
        logic [31:0] stamp;
    } t_parse_result;

    logic                            i_clk        = 1'b0;
    logic                            i_rst_n      = 1'b0;
    logic                            i_cfg_wr_en  = 1'b0;
    logic [mbrx_pkg::CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [mbrx_pkg::CFG_DATA_W-1:0] i_cfg_wdata  = '0;
    logic                            i_in_valid   = 1'b0;
    logic [7:0]                      i_rx_byte    = '0;
    logic [31:0]                     i_arrival_ms = '0;
    logic                            i_out_stall  = 1'b0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    logic                            o_frame_accepted;
    logic                            o_crc_error;
    logic                            o_format_error;
    logic                            o_counts_valid;
    logic                            o_speeds_valid;
    logic signed [15:0]              o_left_ticks;
    logic signed [15:0]              o_right_ticks;
    logic signed [15:0]              o_left_speed;
    logic signed [15:0]              o_right_speed;
    logic [31:0]                     o_sample_time_ms;

    modbus_encoder_frame_receiver uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_arrival_ms     (i_arrival_ms),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_accepted (o_frame_accepted),
        .o_crc_error      (o_crc_error),
        .o_format_error   (o_format_error),
        .o_counts_valid   (o_counts_valid),
        .o_speeds_valid   (o_speeds_valid),
        .o_left_ticks     (o_left_ticks),
        .o_right_ticks    (o_right_ticks),
        .o_left_speed     (o_left_speed),
        .o_right_speed    (o_right_speed),
        .o_sample_time_ms (o_sample_time_ms)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver model state and its copy of the registers
    logic [7:0]  m_buf [BUF_BYTES];
    int          m_idx;
    int          m_total;
    logic [31:0] m_prev_time;
    logic [15:0] m_crc;
    logic [15:0] m_counts [mbrx_pkg::CHANNELS];
    logic [15:0] m_speeds [mbrx_pkg::CHANNELS];
    logic [31:0] m_stamp;
    logic        m_counts_seen;
    logic        m_speeds_seen;
    logic [15:0] cfg_timeout;
    logic [1:0]  cfg_lch;
    logic [1:0]  cfg_rch;
    logic        cfg_linv;
    logic        cfg_rinv;

    t_parse_result parse_results [$];
    logic [7:0]    frame_q [$];
    logic [7:0]    payload_q [$];
    logic [31:0]   now_ms;
    int unsigned   items_sent;
    int unsigned   err_count;
    bit            sender_gaps;
    bit            stall_rand;
    bit            hold_req;
    int unsigned   stall_cnt;
    int unsigned   quiet_cycles;

    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ mbrx_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic logic [15:0] apply_invert(input logic [15:0] v, input logic inv);
        if (!inv)
            return v;
        if (v == 16'h8000)
            return 16'h7FFF;
        return 16'h0000 - v;
    endfunction

    function automatic void model_clear();
        m_idx   = 0;
        m_total = 0;
        m_crc   = mbrx_pkg::CRC_INIT;
    endfunction

    function automatic void model_reset();
        model_clear();
        m_prev_time = '0;
        for (int c = 0; c < mbrx_pkg::CHANNELS; c++) begin
            m_counts[c] = '0;
            m_speeds[c] = '0;
        end
        m_stamp       = '0;
        m_counts_seen = 1'b0;
        m_speeds_seen = 1'b0;
        cfg_timeout   = mbrx_pkg::TIMEOUT_RST;
        cfg_lch       = 2'd0;
        cfg_rch       = 2'd1;
        cfg_linv      = 1'b0;
        cfg_rinv      = 1'b0;
    endfunction

    function automatic void model_push(input logic [7:0] b);
        if (m_total == 0 || m_idx + 2 < m_total)
            m_crc = crc_next(m_crc, b);
        m_buf[m_idx % BUF_BYTES] = b;
        m_idx++;
    endfunction

    // advance the frame parser by one byte and queue the status it reports
    function automatic void parse_byte(input logic [7:0] b, input logic [31:0] t);
        t_parse_result r;
        logic [31:0]   gap;
        logic [15:0]   rcv;
        bit            handled;
        r = '{default: '0};
        handled = 0;
        gap = t - m_prev_time;
        if (m_idx != 0 && gap > {16'd0, cfg_timeout}) begin
            r.fmt_err = 1'b1;
            model_clear();
        end
        m_prev_time = t;
        if (m_idx == 0) begin
            if (b == mbrx_pkg::DEV_ADDR)
                model_push(b);
            handled = 1;
        end else if (m_idx == 1) begin
            if (b != mbrx_pkg::FUNC_READ) begin
                r.fmt_err = 1'b1;
                model_clear();
                if (b == mbrx_pkg::DEV_ADDR)
                    model_push(b);
            end else begin
                model_push(b);
            end
            handled = 1;
        end else if (m_idx == 2) begin
            if (b != mbrx_pkg::COUNT_SHORT && b != mbrx_pkg::COUNT_LONG) begin
                r.fmt_err = 1'b1;
                model_clear();
                handled = 1;
            end else begin
                m_total = int'(b) + 5;
            end
        end
        if (!handled) begin
            if (m_idx >= BUF_BYTES) begin
                r.fmt_err = 1'b1;
                model_clear();
            end else begin
                model_push(b);
                if (m_total > 0 && m_idx == m_total) begin
                    rcv = {m_buf[(m_total - 1) % BUF_BYTES], m_buf[(m_total - 2) % BUF_BYTES]};
                    if (rcv != m_crc) begin
                        r.crc_err = 1'b1;
                    end else begin
                        for (int c = 0; c < mbrx_pkg::CHANNELS; c++)
                            m_counts[c] = {m_buf[3 + 2 * c], m_buf[4 + 2 * c]};
                        if (m_total == int'(mbrx_pkg::COUNT_LONG) + 5) begin
                            for (int c = 0; c < mbrx_pkg::CHANNELS; c++)
                                m_speeds[c] = {m_buf[11 + 2 * c], m_buf[12 + 2 * c]};
                            m_speeds_seen = 1'b1;
                        end
                        m_stamp       = t;
                        m_counts_seen = 1'b1;
                        r.accepted    = 1'b1;
                    end
                    model_clear();
                end
            end
        end
        r.counts_ok = m_counts_seen;
        r.speeds_ok = m_speeds_seen;
        r.left_cnt  = apply_invert(m_counts[cfg_lch], cfg_linv);
        r.right_cnt = apply_invert(m_counts[cfg_rch], cfg_rinv);
        r.left_spd  = apply_invert(m_speeds[cfg_lch], cfg_linv);
        r.right_spd = apply_invert(m_speeds[cfg_rch], cfg_rinv);
        r.stamp     = m_stamp;
        parse_results.push_back(r);
    endfunction

    function automatic logic [31:0] in_frame_gap();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return {16'd0, cfg_timeout};
            default: return $urandom_range(0, int'(cfg_timeout));
        endcase
    endfunction

    function automatic logic [31:0] over_gap();
        logic [31:0] g;
        if ($urandom_range(0, 7) == 0)
            g = $urandom();
        else
            g = {16'd0, cfg_timeout} + 32'd1 + $urandom_range(0, 40);
        if (g <= {16'd0, cfg_timeout})
            g = {16'd0, cfg_timeout} + 32'd1;
        return g;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 4))
            0: return mbrx_pkg::DEV_ADDR;
            1: return mbrx_pkg::FUNC_READ;
            2: return $urandom_range(0, 1) ? mbrx_pkg::COUNT_SHORT : mbrx_pkg::COUNT_LONG;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic void random_payload(input int n);
        payload_q.delete();
        repeat (n) payload_q.push_back(8'($urandom()));
    endfunction

    function automatic void build_response();
        logic [15:0] c;
        frame_q = {mbrx_pkg::DEV_ADDR, mbrx_pkg::FUNC_READ, 8'(payload_q.size())};
        foreach (payload_q[i])
            frame_q.push_back(payload_q[i]);
        c = mbrx_pkg::CRC_INIT;
        foreach (frame_q[i])
            c = crc_next(c, frame_q[i]);
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 100)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic send_item(input logic [7:0] b, input logic [31:0] t);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_rx_byte    <= b;
        i_arrival_ms <= t;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        parse_byte(b, t);
        items_sent++;
    endtask

    task automatic send_at(input logic [7:0] b, input logic [31:0] dt);
        now_ms = now_ms + dt;
        send_item(b, now_ms);
    endtask

    task automatic send_frame_q(input logic [31:0] first_dt, input bit at_limit);
        foreach (frame_q[i]) begin
            if (i == 0)
                send_at(frame_q[i], first_dt);
            else if (at_limit)
                send_at(frame_q[i], {16'd0, cfg_timeout});
            else
                send_at(frame_q[i], in_frame_gap());
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (parse_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input mbrx_pkg::t_cfg_idx idx, input logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // unused upper data bits carry random values
    task automatic apply_config(input logic [15:0] tmo, input logic [1:0] lch,
                                input logic [1:0] rch, input logic linv, input logic rinv);
        write_reg(mbrx_pkg::CFG_TIMEOUT, tmo);
        write_reg(mbrx_pkg::CFG_LEFT_CH, {14'($urandom()), lch});
        write_reg(mbrx_pkg::CFG_RIGHT_CH, {14'($urandom()), rch});
        write_reg(mbrx_pkg::CFG_LEFT_INV, {15'($urandom()), linv});
        write_reg(mbrx_pkg::CFG_RIGHT_INV, {15'($urandom()), rinv});
        i_cfg_wr_en <= 1'b0;
        cfg_timeout = tmo;
        cfg_lch     = lch;
        cfg_rch     = rch;
        cfg_linv    = linv;
        cfg_rinv    = rinv;
    endtask

    task automatic random_config();
        logic [15:0] tmo;
        case ($urandom_range(0, 3))
            0: tmo = 16'd0;
            1: tmo = 16'($urandom_range(1, 20));
            2: tmo = 16'($urandom_range(21, 65534));
            default: tmo = 16'hFFFF;
        endcase
        apply_config(tmo, 2'($urandom()), 2'($urandom()), 1'($urandom()), 1'($urandom()));
    endtask

    task automatic random_burst();
        int kind;
        int n;
        int pos;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            random_payload($urandom_range(0, 1) ? 16 : 8);
            build_response();
            if ($urandom_range(0, 9) == 0) begin
                pos = $urandom_range(3, frame_q.size() - 1);
                frame_q[pos] ^= 8'(1 << $urandom_range(0, 7));
            end
            send_frame_q(($urandom_range(0, 3) == 0) ? in_frame_gap() : over_gap(), 0);
        end else if (kind == 7) begin
            n = $urandom_range(1, 6);
            repeat (n) send_at(noise_byte(), $urandom_range(0, 1) ? in_frame_gap() : over_gap());
        end else if (kind == 8) begin
            random_payload($urandom_range(0, 1) ? 16 : 8);
            build_response();
            n = $urandom_range(1, frame_q.size() - 1);
            while (frame_q.size() > n)
                void'(frame_q.pop_back());
            send_frame_q(over_gap(), 0);
        end else begin
            send_at(mbrx_pkg::DEV_ADDR, over_gap());
            if ($urandom_range(0, 1)) begin
                send_at(noise_byte(), in_frame_gap());
            end else begin
                send_at(mbrx_pkg::FUNC_READ, in_frame_gap());
                send_at(noise_byte(), in_frame_gap());
            end
        end
    endtask

    task automatic test_idle_bytes();
        send_at(8'h00, 32'd1);
        send_at(8'hFF, 32'd100);
        send_at(mbrx_pkg::FUNC_READ, 32'd2);
        send_at(8'h55, 32'd3);
    endtask

    task automatic test_extreme_frames();
        payload_q = {8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
        build_response();
        send_frame_q(32'd1, 0);
        payload_q = {8'h7F, 8'hFF, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01,
                     8'h80, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF};
        build_response();
        send_frame_q(32'd1, 0);
    endtask

    task automatic test_frame_errors();
        // corrupted crc
        random_payload(16);
        build_response();
        frame_q[frame_q.size() - 1] ^= 8'h01;
        send_frame_q(over_gap(), 0);
        // wrong function byte aborts the frame, then the address byte starts a new one
        send_at(mbrx_pkg::DEV_ADDR, over_gap());
        send_at(8'h07, 32'd1);
        send_at(mbrx_pkg::DEV_ADDR, 32'd1);
        random_payload(8);
        build_response();
        void'(frame_q.pop_front());
        send_frame_q(32'd1, 0);
        // bad byte counts
        send_at(mbrx_pkg::DEV_ADDR, 32'd1);
        send_at(mbrx_pkg::FUNC_READ, 32'd1);
        send_at(8'h09, 32'd1);
        send_at(mbrx_pkg::DEV_ADDR, 32'd1);
        send_at(mbrx_pkg::FUNC_READ, 32'd1);
        send_at(8'hFF, 32'd1);
        // gap just past the limit aborts and the byte opens a new frame
        send_at(mbrx_pkg::DEV_ADDR, 32'd1);
        send_at(mbrx_pkg::FUNC_READ, 32'd1);
        random_payload(8);
        build_response();
        send_frame_q({16'd0, cfg_timeout} + 32'd1, 1);
        // millisecond counter wraps inside a frame
        now_ms = 32'hFFFF_FFF8;
        random_payload(8);
        build_response();
        send_frame_q(32'd1, 0);
    endtask

    task automatic test_config_extremes();
        drain();
        apply_config(16'd0, 2'd3, 2'd2, 1'b1, 1'b1);
        payload_q = {8'h7F, 8'hFF, 8'h80, 8'h00, 8'h80, 8'h00, 8'h7F, 8'hFF,
                     8'h00, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h01};
        build_response();
        send_frame_q(over_gap(), 0);
        send_at(mbrx_pkg::DEV_ADDR, 32'd5);
        send_at(mbrx_pkg::FUNC_READ, 32'd1);
        drain();
        apply_config(16'hFFFF, 2'd2, 2'd3, 1'b0, 1'b1);
        random_payload(16);
        build_response();
        send_frame_q(over_gap(), 1);
        send_at(mbrx_pkg::DEV_ADDR, 32'd1);
        send_at(mbrx_pkg::FUNC_READ, 32'h0001_0000);
        drain();
        apply_config(16'd5, 2'd1, 2'd0, 1'b1, 1'b0);
        random_payload(16);
        build_response();
        send_frame_q(over_gap(), 0);
    endtask

    task automatic test_backpressure();
        drain();
        sender_gaps = 0;
        stall_rand  = 0;
        @(negedge i_clk);
        hold_req = 1;
        @(posedge i_clk);
        repeat (2) begin
            random_payload(16);
            build_response();
            send_frame_q(over_gap(), 0);
        end
        sender_gaps = 1;
        stall_rand  = 1;
    endtask

    task automatic test_random_traffic(input int unsigned target);
        int unsigned next_cfg;
        next_cfg = items_sent;
        while (items_sent < target) begin
            if (items_sent >= next_cfg) begin
                drain();
                random_config();
                next_cfg    = items_sent + 120 + $urandom_range(0, 60);
                sender_gaps = ($urandom_range(0, 3) != 0);
                stall_rand  = ($urandom_range(0, 3) != 0);
            end
            random_burst();
        end
    endtask

    task automatic test_clean_tail(input int unsigned target);
        drain();
        sender_gaps = 0;
        stall_rand  = 0;
        random_config();
        while (items_sent < target)
            random_burst();
    endtask

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 0;
            stall_cnt = 60;
        end else if (stall_cnt == 0 && stall_rand && $urandom_range(0, 7) == 0) begin
            stall_cnt = $urandom_range(1, 4);
        end
        if (stall_cnt > 0) begin
            i_out_stall <= 1'b1;
            stall_cnt--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_parse_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (parse_results.size() == 0) begin
                report_mismatch("result with nothing pending", 32'd0, 32'd0);
            end else begin
                want = parse_results.pop_front();
                check_field("frame_accepted", o_frame_accepted, want.accepted);
                check_field("crc_error", o_crc_error, want.crc_err);
                check_field("format_error", o_format_error, want.fmt_err);
                check_field("counts_valid", o_counts_valid, want.counts_ok);
                check_field("speeds_valid", o_speeds_valid, want.speeds_ok);
                check_field("left_ticks", {16'h0, o_left_ticks}, want.left_cnt);
                check_field("right_ticks", {16'h0, o_right_ticks}, want.right_cnt);
                check_field("left_speed", {16'h0, o_left_speed}, want.left_spd);
                check_field("right_speed", {16'h0, o_right_speed}, want.right_spd);
                check_field("sample_time_ms", o_sample_time_ms, want.stamp);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        model_reset();
        now_ms       = '0;
        items_sent   = 0;
        err_count    = 0;
        stall_cnt    = 0;
        quiet_cycles = 0;
        hold_req     = 0;
        sender_gaps  = 0;
        stall_rand   = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_gaps = 1;
        stall_rand  = 1;
        test_idle_bytes();
        test_extreme_frames();
        test_frame_errors();
        test_config_extremes();
        test_backpressure();
        test_random_traffic(640);
        test_clean_tail(750);
        drain();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && parse_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/mbrx_pkg.sv
rtl/mbrx_parser.sv
rtl/modbus_encoder_frame_receiver.sv
sim/tb_top.sv
